/* hdl/q2e_pkg.sv */
// Shared types, widths and constants for the quaternion to z-y-x Euler angle core.
// No dependencies.
package q2e_pkg;

    localparam int QW           = 16;
    localparam int PW           = 32;
    localparam int SW           = 35;
    localparam int CordicSteps  = 16;
    localparam int AngTableSize = 24;
    localparam int StepW        = $clog2(AngTableSize);
    localparam int IsqrtSteps   = 31;
    localparam int DelayLen     = IsqrtSteps + 2;
    localparam int RootW        = 2 * IsqrtSteps - 1;
    localparam int XW           = 37;
    localparam int ZW           = 26;
    localparam int RollYawLimit = 23040;
    localparam int PitchLimit   = 11520;

    localparam logic signed [ZW-1:0] Deg90 = ZW'(90 * 65536);

    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic [RootW-1:0] n;
        logic [RootW-1:0] res;
    } root_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic signed [ZW-1:0] atan_angle(input int idx);
        logic signed [ZW-1:0] a;
        case (idx)
            0:       a = ZW'(2949120);
            1:       a = ZW'(1740967);
            2:       a = ZW'(919879);
            3:       a = ZW'(466945);
            4:       a = ZW'(234379);
            5:       a = ZW'(117304);
            6:       a = ZW'(58666);
            7:       a = ZW'(29335);
            8:       a = ZW'(14668);
            9:       a = ZW'(7334);
            10:      a = ZW'(3667);
            11:      a = ZW'(1833);
            12:      a = ZW'(917);
            13:      a = ZW'(458);
            14:      a = ZW'(229);
            15:      a = ZW'(115);
            16:      a = ZW'(57);
            17:      a = ZW'(29);
            18:      a = ZW'(14);
            19:      a = ZW'(7);
            20:      a = ZW'(4);
            21:      a = ZW'(2);
            22:      a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

/* hdl/q2e_cordic_cell.sv */
// One vectoring CORDIC micro-rotation, registered.
// Depends on q2e_pkg.
module q2e_cordic_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  q2e_pkg::cordic_t              cell_in,
    input  logic [q2e_pkg::StepW-1:0]     step,
    input  logic signed [q2e_pkg::ZW-1:0] angle,
    output q2e_pkg::cordic_t              cell_out
);
    import q2e_pkg::*;

    logic                 valid_reg;
    cordic_t              data_reg;
    cordic_t              data_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    always_comb
    begin
        xs = cell_in.x >>> step;
        ys = cell_in.y >>> step;
        data_next = cell_in;
        if (!cell_in.y[XW-1])
        begin
            data_next.x = cell_in.x + ys;
            data_next.y = cell_in.y - xs;
            data_next.z = cell_in.z + angle;
        end
        else
        begin
            data_next.x = cell_in.x - ys;
            data_next.y = cell_in.y + xs;
            data_next.z = cell_in.z - angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cell_in.valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        cell_out = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule

/* hdl/q2e_isqrt_cell.sv */
// One digit step of the floor integer square root, registered.
// Depends on q2e_pkg.
module q2e_isqrt_cell (
    input  logic                        clk,
    input  q2e_pkg::root_t              cell_in,
    input  logic [q2e_pkg::RootW-1:0]   bit_val,
    output q2e_pkg::root_t              cell_out
);
    import q2e_pkg::*;

    logic [RootW:0] trial;
    root_t          data_next;
    root_t          data_reg;

    always_comb
    begin
        trial = {1'b0, cell_in.res} + {1'b0, bit_val};
        if ({1'b0, cell_in.n} >= trial)
        begin
            data_next.n   = cell_in.n - trial[RootW-1:0];
            data_next.res = (cell_in.res >> 1) + bit_val;
        end
        else
        begin
            data_next.n   = cell_in.n;
            data_next.res = cell_in.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign cell_out = data_reg;

endmodule

/* hdl/quaternion_to_euler_zyx_core.sv */
// Top level: quaternion (Q1.15) to roll, pitch, yaw in 1/128 degree, z-y-x order.
// Depends on q2e_pkg, q2e_isqrt_cell, q2e_cordic_cell.
//
//  channel   | handshake        | payload
//  ----------+------------------+-------------------------------------------------
//  request   | start, busy      | quat_w, quat_x, quat_y, quat_z
//  result    | done (strobe)    | roll_angle, pitch_angle, yaw_angle, pitch_saturated
//
// One request per cycle; busy stays low. The pipeline depth is set by the 31-cell
// square root row and the 16-cell CORDIC rows.
// Reset clears the valid bits of every stage; results in flight are dropped.
// Each result shows for one cycle with done; the receiver cannot stall.
module quaternion_to_euler_zyx_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [q2e_pkg::QW-1:0] quat_w,
    input  logic signed [q2e_pkg::QW-1:0] quat_x,
    input  logic signed [q2e_pkg::QW-1:0] quat_y,
    input  logic signed [q2e_pkg::QW-1:0] quat_z,
    output logic                          done,
    output logic signed [15:0]            roll_angle,
    output logic signed [14:0]            pitch_angle,
    output logic signed [15:0]            yaw_angle,
    output logic                          pitch_saturated
);
    import q2e_pkg::*;

    localparam int Latency = DelayLen + CordicSteps + 4;
    localparam int MagW    = 30;

    typedef struct packed {
        logic signed [SW-1:0] sinr;
        logic signed [SW-1:0] cosr;
        logic signed [SW-1:0] sinp;
        logic signed [SW-1:0] siny;
        logic signed [SW-1:0] cosy;
        logic                 sat;
    } src_t;

    typedef struct packed {
        logic sat;
        logic neg;
    } flag_t;

    function automatic logic signed [ZW-1:0] clamp_angle(
        input logic signed [ZW-1:0] a,
        input int                   lim
    );
        logic signed [ZW-1:0] hi;
        logic signed [ZW-1:0] r;
        hi = ZW'(lim);
        if (a > hi)
            r = hi;
        else if (a < -hi)
            r = -hi;
        else
            r = a;
        return r;
    endfunction

    // products
    logic                 v1_reg;
    logic signed [PW-1:0] p_yz_reg, p_wx_reg, p_xx_reg, p_yy_reg, p_wy_reg;
    logic signed [PW-1:0] p_xz_reg, p_xy_reg, p_wz_reg, p_zz_reg;

    // sums
    logic                 v2_reg;
    src_t                 src_reg;
    src_t                 src_next;
    logic [MagW-1:0]      mag_reg;
    logic [MagW-1:0]      mag_next;

    logic [2*MagW-1:0]    msq_reg;
    root_t                rem_reg;
    root_t                root_chain [IsqrtSteps+1];

    logic                 dv_reg  [DelayLen];
    src_t                 dly_reg [DelayLen];

    cordic_t              pre_reg  [3];
    cordic_t              pre_next [3];
    cordic_t              chain    [3][CordicSteps+1];
    logic signed [XW-1:0] in_x [3];
    logic signed [XW-1:0] in_y [3];
    flag_t                flag_reg [CordicSteps+1];

    logic signed [ZW-1:0] rounded [3];
    logic signed [ZW-1:0] final_ang [3];

    logic                 done_reg;
    logic signed [15:0]   roll_reg;
    logic signed [14:0]   pitch_reg;
    logic signed [15:0]   yaw_reg;
    logic                 sat_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_yz_reg <= quat_y * quat_z;
        p_wx_reg <= quat_w * quat_x;
        p_xx_reg <= quat_x * quat_x;
        p_yy_reg <= quat_y * quat_y;
        p_wy_reg <= quat_w * quat_y;
        p_xz_reg <= quat_x * quat_z;
        p_xy_reg <= quat_x * quat_y;
        p_wz_reg <= quat_w * quat_z;
        p_zz_reg <= quat_z * quat_z;
    end

    always_comb
    begin
        src_next.sinr = (SW'(p_yz_reg) + SW'(p_wx_reg)) <<< 1;
        src_next.cosr = (SW'(1) <<< 30) - ((SW'(p_xx_reg) + SW'(p_yy_reg)) <<< 1);
        src_next.sinp = (SW'(p_wy_reg) - SW'(p_xz_reg)) <<< 1;
        src_next.siny = (SW'(p_xy_reg) + SW'(p_wz_reg)) <<< 1;
        src_next.cosy = (SW'(1) <<< 30) - ((SW'(p_yy_reg) + SW'(p_zz_reg)) <<< 1);
        src_next.sat  = (src_next.sinp >= (SW'(1) <<< 30)) ||
                        (src_next.sinp <= -(SW'(1) <<< 30));
        if (src_next.sinp[SW-1])
            mag_next = MagW'(-src_next.sinp);
        else
            mag_next = MagW'(src_next.sinp);
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        mag_reg <= mag_next;
        msq_reg <= mag_reg * mag_reg;
        rem_reg.n   <= (RootW'(1) << (RootW - 1)) - RootW'(msq_reg);
        rem_reg.res <= '0;
    end

    // pitch cosine: floor sqrt(1 - s^2)
    assign root_chain[0] = rem_reg;

    for (genvar i = 0; i < IsqrtSteps; i++)
    begin : g_root
        q2e_isqrt_cell u_isqrt (
            .clk      (clk),
            .cell_in  (root_chain[i]),
            .bit_val  (RootW'(1) << (RootW - 1 - 2 * i)),
            .cell_out (root_chain[i+1])
        );
    end

    // alignment with the square root row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DelayLen; k++)
                dv_reg[k] <= 1'b0;
        end
        else
        begin
            dv_reg[0] <= v2_reg;
            for (int k = 1; k < DelayLen; k++)
                dv_reg[k] <= dv_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        dly_reg[0] <= src_reg;
        for (int k = 1; k < DelayLen; k++)
            dly_reg[k] <= dly_reg[k-1];
    end

    // quadrant fold ahead of the CORDIC rows
    always_comb
    begin
        in_y[0] = XW'(dly_reg[DelayLen-1].sinr);
        in_x[0] = XW'(dly_reg[DelayLen-1].cosr);
        in_y[1] = XW'(dly_reg[DelayLen-1].sinp);
        in_x[1] = XW'($signed({1'b0, root_chain[IsqrtSteps].res[IsqrtSteps-1:0]}));
        in_y[2] = XW'(dly_reg[DelayLen-1].siny);
        in_x[2] = XW'(dly_reg[DelayLen-1].cosy);
        for (int c = 0; c < 3; c++)
        begin
            pre_next[c].valid = dv_reg[DelayLen-1];
            pre_next[c].zero  = (in_x[c] == '0) && (in_y[c] == '0);
            if (in_x[c][XW-1])
            begin
                if (!in_y[c][XW-1])
                begin
                    pre_next[c].x = in_y[c];
                    pre_next[c].y = -in_x[c];
                    pre_next[c].z = Deg90;
                end
                else
                begin
                    pre_next[c].x = -in_y[c];
                    pre_next[c].y = in_x[c];
                    pre_next[c].z = -Deg90;
                end
            end
            else
            begin
                pre_next[c].x = in_x[c];
                pre_next[c].y = in_y[c];
                pre_next[c].z = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
                pre_reg[c] <= '0;
        end
        else
        begin
            for (int c = 0; c < 3; c++)
                pre_reg[c] <= pre_next[c];
        end
    end

    always_ff @(posedge clk)
    begin
        flag_reg[0].sat <= dly_reg[DelayLen-1].sat;
        flag_reg[0].neg <= dly_reg[DelayLen-1].sinp[SW-1];
        for (int k = 1; k <= CordicSteps; k++)
            flag_reg[k] <= flag_reg[k-1];
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        assign chain[c][0] = pre_reg[c];
        for (genvar i = 0; i < CordicSteps; i++)
        begin : g_step
            q2e_cordic_cell u_cordic (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_in  (chain[c][i]),
                .step     (StepW'(i)),
                .angle    (atan_angle(i)),
                .cell_out (chain[c][i+1])
            );
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rounded[c] = (chain[c][CordicSteps].z + ZW'(256)) >>> 9;
            if (chain[c][CordicSteps].zero)
                final_ang[c] = '0;
            else
                final_ang[c] = rounded[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain[0][CordicSteps].valid;
    end

    always_ff @(posedge clk)
    begin
        roll_reg <= 16'(clamp_angle(final_ang[0], RollYawLimit));
        yaw_reg  <= 16'(clamp_angle(final_ang[2], RollYawLimit));
        sat_reg  <= flag_reg[CordicSteps].sat;
        if (flag_reg[CordicSteps].sat)
        begin
            if (flag_reg[CordicSteps].neg)
                pitch_reg <= -15'(PitchLimit);
            else
                pitch_reg <= 15'(PitchLimit);
        end
        else
            pitch_reg <= 15'(clamp_angle(final_ang[1], PitchLimit));
    end

    assign done            = done_reg;
    assign roll_angle      = roll_reg;
    assign pitch_angle     = pitch_reg;
    assign yaw_angle       = yaw_reg;
    assign pitch_saturated = sat_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##Latency done)
        else $error("request did not produce a result at the expected latency");

    a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        done && pitch_saturated |-> pitch_angle == 15'sd11520 || pitch_angle == -15'sd11520)
        else $error("saturated pitch not at a pole");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> roll_angle <= 16'sd23040 && roll_angle >= -16'sd23040 &&
                 yaw_angle <= 16'sd23040 && yaw_angle >= -16'sd23040)
        else $error("roll or yaw outside its range");

endmodule

/* bench/q2e_checker.sv */
`timescale 1ns / 1ps
// Checker for the quaternion to z-y-x Euler core: predicts angles per request, compares on done.
// Depends on q2e_pkg (widths, limits, CORDIC step count).
module q2e_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic signed [q2e_pkg::QW-1:0] quat_w,
    input  logic signed [q2e_pkg::QW-1:0] quat_x,
    input  logic signed [q2e_pkg::QW-1:0] quat_y,
    input  logic signed [q2e_pkg::QW-1:0] quat_z,
    input  logic                          done,
    input  logic signed [15:0]            roll_angle,
    input  logic signed [14:0]            pitch_angle,
    input  logic signed [15:0]            yaw_angle,
    input  logic                          pitch_saturated,
    output int                            fail_count,
    output int                            pending
);
    import q2e_pkg::*;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               sat;
    } angles_t;

    angles_t angle_queue[$];

    localparam longint OneQ30 = 64'sd1 << 30;

    function automatic longint angle_of(input int idx);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tab[idx];
    endfunction

    function automatic longint vector_angle(input longint yi, input longint xi);
        longint vx, vy, vz, sx, sy, t;
        vx = xi;
        vy = yi;
        vz = 0;
        if (vx == 0 && vy == 0)
            return 0;
        if (vx < 0)
        begin
            t = vx;
            if (vy >= 0)
            begin
                vx = vy; vy = -t; vz = 90 * 65536;
            end
            else
            begin
                vx = -vy; vy = t; vz = -90 * 65536;
            end
        end
        for (int i = 0; i < (CordicSteps > 24 ? 24 : CordicSteps); i++)
        begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0)
            begin
                vx += sy; vy -= sx; vz += angle_of(i);
            end
            else
            begin
                vx -= sy; vy += sx; vz -= angle_of(i);
            end
        end
        return (vz + 256) >>> 9;
    endfunction

    function automatic longint clamp(input longint v, input longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic longint floor_root(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic angles_t euler_of(input longint w, input longint x,
                                         input longint y, input longint z);
        angles_t a;
        longint sp, mag, p;
        a.roll = 16'(clamp(vector_angle(2 * (y * z + w * x), OneQ30 - 2 * (x * x + y * y)),
                           RollYawLimit));
        a.yaw = 16'(clamp(vector_angle(2 * (x * y + w * z), OneQ30 - 2 * (y * y + z * z)),
                          RollYawLimit));
        sp = 2 * (w * y - x * z);
        if (sp >= OneQ30 || sp <= -OneQ30)
        begin
            p = sp > 0 ? PitchLimit : -PitchLimit;
            a.sat = 1'b1;
        end
        else
        begin
            mag = sp < 0 ? -sp : sp;
            p = clamp(vector_angle(sp, floor_root((64'd1 << 60) - mag * mag)), PitchLimit);
            a.sat = 1'b0;
        end
        a.pitch = 15'(p);
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        angles_t e;
        if (!rst_n)
        begin
            angle_queue.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (start && !busy)
                angle_queue.push_back(euler_of(quat_w, quat_x, quat_y, quat_z));
            if (done)
            begin
                if (angle_queue.size() == 0)
                begin
                    $error("result with no request waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = angle_queue.pop_front();
                    if (roll_angle !== e.roll || pitch_angle !== e.pitch ||
                        yaw_angle !== e.yaw || pitch_saturated !== e.sat)
                        fail_count <= fail_count + 1;
                    if (roll_angle !== e.roll)
                        $error("roll_angle expected %0d got %0d", e.roll, roll_angle);
                    if (pitch_angle !== e.pitch)
                        $error("pitch_angle expected %0d got %0d", e.pitch, pitch_angle);
                    if (yaw_angle !== e.yaw)
                        $error("yaw_angle expected %0d got %0d", e.yaw, yaw_angle);
                    if (pitch_saturated !== e.sat)
                        $error("pitch_saturated expected %0b got %0b", e.sat, pitch_saturated);
                end
            end
            pending <= angle_queue.size();
        end
    end
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Testbench top: clock, reset, directed and random quaternion requests, verdict.
// Depends on q2e_pkg, quaternion_to_euler_zyx_core and q2e_checker.
module testbench;
    import q2e_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy, done, pitch_saturated;
    logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic signed [15:0] roll_angle, yaw_angle;
    logic signed [14:0] pitch_angle;
    int fail_count, pending;
    int idle_pct;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    quaternion_to_euler_zyx_core DUT (.*);
    q2e_checker checker_i (.*);

    task automatic send(input logic [15:0] w, x, y, z);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(46340)) - 23170);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        #20000000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        logic [15:0] ex[6];
        ex = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5A82};
        idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(16'h7FFF, 0, 0, 0);
        send(0, 0, 0, 0);
        send(16'h5A82, 0, 16'h5A82, 0);
        send(16'h5A82, 0, 16'hA57E, 0);
        send(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send(0, 16'h7FFF, 0, 0);
        send(0, 0, 0, 16'h7FFF);
        send(16'h5A82, 16'h5A82, 0, 0);
        send(16'h5A82, 0, 0, 16'hA57E);
        for (int i = 0; i < 12; i++)
            send(ex[$urandom_range(5)], ex[$urandom_range(5)], ex[$urandom_range(5)],
                 ex[$urandom_range(5)]);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = ph == 0 ? 0 : (ph == 1 ? 48 : (ph == 2 ? 0 : 21));
            for (int i = 0; i < 120; i++)
                send(pick(), pick(), pick(), pick());
        end
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
